>>> design/weighted_least_squares_scaler_macros.svh
// assertion macros shared by the scale factor unit
// depends on nothing; taken in by the modules that carry assertions
`ifndef WEIGHTED_LEAST_SQUARES_SCALER_MACROS_SVH
`define WEIGHTED_LEAST_SQUARES_SCALER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WLSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WLSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/wlss_pkg.sv
// shared types and constants of the weighted least-squares scale factor unit
// no dependencies
`timescale 1ns / 1ps

package wlss_pkg;

	// field and storage widths
	localparam int WEIGHT_W      = 16;
	localparam int DATA_W        = 24;
	localparam int SUM_W         = 56;
	localparam int QUO_W         = 23;
	localparam int CNT_W         = $clog2(QUO_W);
	localparam int FRAC_BITS_DEF = 16;

	// saturation limits of a Q8.16 result
	localparam logic [DATA_W-1:0] RES_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] RES_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// request opcodes
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_SCALE = 1'b1;

	// result kinds
	localparam logic KIND_FACTOR = 1'b0;
	localparam logic KIND_SCALE  = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic mul_a;
		logic mul_b;
		logic accum;
		logic div_start;
		logic div_step;
		logic emit_factor;
		logic emit_scale;
	} wlss_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic opcode;
		logic last;
		logic skip_div;
		logic div_last;
		logic out_full;
	} wlss_sts_t;

endpackage

>>> design/wlss_ctrl.sv
// controller state machine of the scale factor unit
// depends on wlss_pkg
`timescale 1ns / 1ps

module wlss_ctrl import wlss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output wlss_cmd_t cmd,
	input  wlss_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL_A,
		S_MUL_B,
		S_ACC,
		S_DIV_START,
		S_DIV,
		S_EMIT_F,
		S_EMIT_S
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL_A;
				end
			end
			S_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = (sts.opcode == OP_SCALE) ? S_EMIT_S : S_MUL_B;
			end
			S_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d   = S_ACC;
			end
			S_ACC: begin
				cmd.accum = 1'b1;
				state_d   = sts.last ? S_DIV_START : S_IDLE;
			end
			S_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = sts.skip_div ? S_EMIT_F : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_EMIT_F;
				end
			end
			S_EMIT_F: begin
				if (!sts.out_full) begin
					cmd.emit_factor = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_EMIT_S: begin
				if (!sts.out_full) begin
					cmd.emit_scale = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and registered stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

	assign in_stall = stall_q;

endmodule

>>> design/wlss_dp.sv
// datapath of the scale factor unit: multipliers, sums, divider, output register
// depends on wlss_pkg and weighted_least_squares_scaler_macros.svh
`timescale 1ns / 1ps

`include "weighted_least_squares_scaler_macros.svh"

module wlss_dp import wlss_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  wlss_cmd_t                cmd,
	output wlss_sts_t                sts,
	input  logic                     opcode,
	input  logic [WEIGHT_W-1:0]      weight,
	input  logic [DATA_W-1:0]        distance,
	input  logic [DATA_W-1:0]        target,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     kind,
	output logic signed [DATA_W-1:0] result_value,
	output logic                     divide_by_zero
);

	localparam int WD_W   = WEIGHT_W + DATA_W;
	localparam int PROD_W = WD_W + DATA_W;
	localparam int SP_W   = 2 * DATA_W;
	localparam int SH     = 2 * FRAC_BITS - 16;
	localparam int SAT_SH = QUO_W - FRAC_BITS;
	localparam int DEN_W  = SUM_W + SAT_SH;
	localparam int XW     = SUM_W + FRAC_BITS;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam logic signed [SP_W:0] SMAX = {{(SP_W+1-DATA_W){1'b0}}, RES_MAX};
	localparam logic signed [SP_W:0] SMIN = {{(SP_W+1-DATA_W){1'b1}}, RES_MIN};

	// captured request
	logic                     op_q;
	logic                     last_q;
	logic [WEIGHT_W-1:0]      w_q;
	logic [DATA_W-1:0]        d_q;
	logic [DATA_W-1:0]        t_q;
	logic signed [DATA_W-1:0] v_q;

	// products
	logic [WD_W-1:0]          wd_q;
	logic signed [SP_W-1:0]   sprod_q;
	logic [PROD_W-1:0]        pc_q;
	logic [PROD_W-1:0]        ps_q;

	// state
	logic [SUM_W-1:0]         cross_q;
	logic [SUM_W-1:0]         square_q;
	logic [DATA_W-1:0]        factor_q;

	// divider
	logic [SUM_W-1:0]         rem_q;
	logic [QUO_W-1:0]         qb_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     dz_q;
	logic                     sat_q;

	// output register
	logic                     out_valid_q;
	logic                     kind_q;
	logic [DATA_W-1:0]        res_q;
	logic                     dzo_q;

	logic [WD_W-1:0]          wd_c;
	logic signed [SP_W-1:0]   sp_c;
	logic [PROD_W-1:0]        add_c_c;
	logic [PROD_W-1:0]        add_s_c;
	logic [PROD_W:0]          sum_c_c;
	logic [PROD_W:0]          sum_s_c;
	logic [SUM_W-1:0]         cross_nx;
	logic [SUM_W-1:0]         square_nx;
	logic [DEN_W-1:0]         den_sh;
	logic                     sat_c;
	logic [XW-1:0]            x_c;
	logic [SUM_W:0]           trial_c;
	logic [SUM_W:0]           diff_c;
	logic                     ge_c;
	logic [DATA_W-1:0]        fac_new;
	logic signed [SP_W:0]     rnd_c;
	logic signed [SP_W:0]     shf_c;
	logic [DATA_W-1:0]        scale_res;

	// multipliers
	assign wd_c = WD_W'(w_q) * WD_W'(d_q);
	assign sp_c = v_q * $signed(factor_q);

	// truncate products to 31 fraction bits and add with saturation
	assign add_c_c  = pc_q >> SH;
	assign add_s_c  = ps_q >> SH;
	assign sum_c_c  = (PROD_W+1)'(cross_q) + (PROD_W+1)'(add_c_c);
	assign sum_s_c  = (PROD_W+1)'(square_q) + (PROD_W+1)'(add_s_c);
	assign cross_nx  = (sum_c_c >= (PROD_W+1)'(SUM_MAX)) ? SUM_MAX : sum_c_c[SUM_W-1:0];
	assign square_nx = (sum_s_c >= (PROD_W+1)'(SUM_MAX)) ? SUM_MAX : sum_s_c[SUM_W-1:0];

	// quotient overflow check and dividend set-up
	assign den_sh = {square_q, {SAT_SH{1'b0}}};
	assign sat_c  = DEN_W'(cross_q) >= den_sh;
	assign x_c    = {cross_q, {FRAC_BITS{1'b0}}};

	// one restoring division step
	assign trial_c = {rem_q, qb_q[QUO_W-1]};
	assign ge_c    = trial_c >= {1'b0, square_q};
	assign diff_c  = trial_c - {1'b0, square_q};

	// factor after a closed data set
	always_comb begin
		if (dz_q) begin
			fac_new = factor_q;
		end else if (sat_q) begin
			fac_new = RES_MAX;
		end else begin
			fac_new = {1'b0, qb_q};
		end
	end

	// scaled value: round half up, then saturate
	assign rnd_c = (SP_W+1)'(sprod_q) + ((SP_W+1)'(1) << (FRAC_BITS - 1));
	assign shf_c = rnd_c >>> FRAC_BITS;
	always_comb begin
		if (shf_c > SMAX) begin
			scale_res = RES_MAX;
		end else if (shf_c < SMIN) begin
			scale_res = RES_MIN;
		end else begin
			scale_res = shf_c[DATA_W-1:0];
		end
	end

	// sums, factor and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cross_q     <= '0;
			square_q    <= '0;
			factor_q    <= DATA_W'(1) << FRAC_BITS;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accum) begin
				cross_q  <= cross_nx;
				square_q <= square_nx;
			end else if (cmd.emit_factor) begin
				cross_q  <= '0;
				square_q <= '0;
				factor_q <= fac_new;
			end
			if (cmd.emit_factor || cmd.emit_scale) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture, products, divider and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			last_q <= last;
			w_q    <= weight;
			d_q    <= distance;
			t_q    <= target;
			v_q    <= value;
		end
		if (cmd.mul_a) begin
			wd_q    <= wd_c;
			sprod_q <= sp_c;
		end
		if (cmd.mul_b) begin
			pc_q <= PROD_W'(wd_q) * PROD_W'(t_q);
			ps_q <= PROD_W'(wd_q) * PROD_W'(d_q);
		end
		if (cmd.div_start) begin
			dz_q  <= (square_q == '0);
			sat_q <= sat_c;
			rem_q <= SUM_W'(x_c[XW-1:QUO_W]);
			qb_q  <= x_c[QUO_W-1:0];
			cnt_q <= CNT_W'(QUO_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= ge_c ? diff_c[SUM_W-1:0] : trial_c[SUM_W-1:0];
			qb_q  <= {qb_q[QUO_W-2:0], ge_c};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.emit_factor) begin
			kind_q <= KIND_FACTOR;
			res_q  <= fac_new;
			dzo_q  <= dz_q;
		end else if (cmd.emit_scale) begin
			kind_q <= KIND_SCALE;
			res_q  <= scale_res;
			dzo_q  <= 1'b0;
		end
	end

	// status to the controller
	assign sts.opcode   = op_q;
	assign sts.last     = last_q;
	assign sts.skip_div = (square_q == '0) || sat_c;
	assign sts.div_last = (cnt_q == '0);
	assign sts.out_full = out_valid_q && out_stall;

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign result_value   = $signed(res_q);
	assign divide_by_zero = dzo_q;

	// checks
	`WLSS_ASSERT_NOW(a_div_nonzero, clk, arst_n, cmd.div_step, square_q != '0, "division by zero sum")
	`WLSS_ASSERT_NOW(a_rem_below, clk, arst_n, cmd.div_step, rem_q < square_q, "remainder not below divisor")
	`WLSS_ASSERT_NOW(a_factor_pos, clk, arst_n, cmd.emit_factor, !fac_new[DATA_W-1], "negative scale factor")
	`WLSS_ASSERT_NEXT(a_sums_clear, clk, arst_n, cmd.emit_factor, (cross_q == '0) && (square_q == '0), "sums not cleared")

endmodule

>>> design/weighted_least_squares_scaler.sv
// Weighted least-squares scale factor unit, top level.
// Input channel (in_valid / in_stall): opcode 0 accumulates one element (weight,
// distance, target); with last set it closes the data set and yields the new
// scale factor cross_sum / square_sum in Q8.16. Opcode 1 returns value times the
// factor, rounded half up and saturated.
// Output channel (out_valid / out_stall): kind, result_value, divide_by_zero.
// A non-last accumulate request gives no result and passes the two multiply
// stages and the accumulate; a scale request passes the first multiply stage
// and then registers its result in the scale emit state. A last element
// passes two multiply stages, the accumulate, the zero and overflow check and
// 23 steps of the restoring divider, one quotient bit each.
// When the square sum is zero or the quotient saturates the divider is skipped.
// Requests are taken one at a time; the controller decides when in_stall drops.
// The output register holds a result while out_stall is high; the next request
// is taken meanwhile and waits for the register only at its result.
// Reset clears both sums, sets the factor to 1.0 and empties the output.
// depends on wlss_pkg, wlss_ctrl and wlss_dp
`timescale 1ns / 1ps

module weighted_least_squares_scaler import wlss_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     opcode,
	input  logic [WEIGHT_W-1:0]      weight,
	input  logic [DATA_W-1:0]        distance,
	input  logic [DATA_W-1:0]        target,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     kind,
	output logic signed [DATA_W-1:0] result_value,
	output logic                     divide_by_zero
);

	wlss_cmd_t cmd;
	wlss_sts_t sts;

	// sequencer
	wlss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic and result register
	wlss_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.weight         (weight),
		.distance       (distance),
		.target         (target),
		.value          (value),
		.last           (last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.result_value   (result_value),
		.divide_by_zero (divide_by_zero)
	);

endmodule

>>> sim/testbench.sv
// self-checking testbench of the weighted least-squares scale factor unit
// holds its own bit-true predictor in a small scoreboard class and drives both channels
// depends on wlss_pkg and weighted_least_squares_scaler
`timescale 1ns / 1ps

module testbench;
	import wlss_pkg::*;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int RANDOM_ITEMS   = 840;
	localparam int TAIL_CYCLES    = 40;
	localparam int HOLD_OFF_LEN   = 300;
	localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
	localparam logic [WEIGHT_W-1:0] W_ONE = 16'h8000;
	localparam logic [DATA_W-1:0] D_MAX   = {DATA_W{1'b1}};

	// one result as the block presents it
	typedef struct {
		logic              kind;
		logic [DATA_W-1:0] value;
		logic              dz;
	} wlss_result_t;

	// running sums, current factor and the results still owed by the block
	class wlss_scoreboard;
		logic [63:0]       cross_acc;
		logic [63:0]       square_acc;
		logic [DATA_W-1:0] factor;
		wlss_result_t      owed_q[$];
		int                mismatches;

		function new();
			cross_acc  = '0;
			square_acc = '0;
			factor     = DATA_W'(1) << FRAC;
			mismatches = 0;
		endfunction

		// saturating add at the width of the hardware sums
		function logic [63:0] sat_add(logic [63:0] acc, logic [63:0] add);
			if (acc > SUM_LIMIT)
				acc = SUM_LIMIT;
			if (add >= SUM_LIMIT - acc)
				return SUM_LIMIT;
			return acc + add;
		endfunction

		// weight times two data values, cut back to 31 fraction bits
		function logic [63:0] weighted_product(logic [WEIGHT_W-1:0] w, logic [DATA_W-1:0] a,
				logic [DATA_W-1:0] b);
			logic [63:0] p;
			p = 64'(w) * 64'(a) * 64'(b);
			return p >> (2 * FRAC - 16);
		endfunction

		// cross over square, truncated, saturated once the integer part is too wide
		function logic [DATA_W-1:0] quotient(logic [63:0] num, logic [63:0] den);
			logic [127:0] q;
			if (num / den >= (64'd1 << (QUO_W - FRAC)))
				return RES_MAX;
			q = {64'd0, num} << FRAC;
			q = q / {64'd0, den};
			return q[DATA_W-1:0];
		endfunction

		// value times factor, rounded half up, saturated
		function logic [DATA_W-1:0] scaled(logic signed [DATA_W-1:0] v);
			logic signed [63:0] vx;
			logic signed [63:0] fx;
			logic signed [63:0] r;
			vx = v;
			fx = $signed({40'd0, factor});
			r  = (vx * fx + (64'sd1 << (FRAC - 1))) >>> FRAC;
			if (r > 64'sd8388607)
				return RES_MAX;
			if (r < -64'sd8388608)
				return RES_MIN;
			return r[DATA_W-1:0];
		endfunction

		// an accepted request: update the sums and note any result it owes
		function void note_request(logic op, logic [WEIGHT_W-1:0] w, logic [DATA_W-1:0] d,
				logic [DATA_W-1:0] t, logic signed [DATA_W-1:0] v, logic l);
			wlss_result_t res;
			if (op == OP_ACCUM) begin
				cross_acc  = sat_add(cross_acc, weighted_product(w, d, t));
				square_acc = sat_add(square_acc, weighted_product(w, d, d));
				if (!l)
					return;
				res.dz = (square_acc == 0);
				if (!res.dz)
					factor = quotient(cross_acc, square_acc);
				cross_acc  = '0;
				square_acc = '0;
				res.kind   = KIND_FACTOR;
				res.value  = factor;
			end else begin
				res.kind  = KIND_SCALE;
				res.value = scaled(v);
				res.dz    = 1'b0;
			end
			owed_q.push_back(res);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		endtask

		// compare one accepted result with the oldest one owed
		task check_result(logic k, logic [DATA_W-1:0] val, logic dz);
			wlss_result_t want;
			if (owed_q.size() == 0) begin
				report_mismatch("result with no request waiting", 32'(val), 32'd0);
				return;
			end
			want = owed_q.pop_front();
			if (k !== want.kind)
				report_mismatch("kind", 32'(k), 32'(want.kind));
			if (val !== want.value)
				report_mismatch("result_value", 32'(val), 32'(want.value));
			if (dz !== want.dz)
				report_mismatch("divide_by_zero", 32'(dz), 32'(want.dz));
		endtask

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n   = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     opcode   = OP_ACCUM;
	logic [WEIGHT_W-1:0]      weight   = '0;
	logic [DATA_W-1:0]        distance = '0;
	logic [DATA_W-1:0]        target   = '0;
	logic signed [DATA_W-1:0] value    = '0;
	logic                     last     = 1'b0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     kind;
	logic signed [DATA_W-1:0] result_value;
	logic                     divide_by_zero;

	wlss_scoreboard sb;
	int   cycle_count   = 0;
	int   requests_sent = 0;
	logic calm          = 1'b0;
	logic hold_off_req  = 1'b0;

	weighted_least_squares_scaler #(
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.weight        (weight),
		.distance      (distance),
		.target        (target),
		.value         (value),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.result_value  (result_value),
		.divide_by_zero(divide_by_zero)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// idle lengths: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return W_ONE;
			default: return WEIGHT_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return D_MAX;
			2:       return DATA_W'($urandom_range(0, 255));
			3:       return DATA_W'($urandom_range(0, 65535)) << 8;
			default: return DATA_W'($urandom());
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return RES_MIN;
			1:       return RES_MAX;
			2:       return DATA_W'($urandom_range(0, 3)) ^ {DATA_W{$urandom_range(0, 1) == 1}};
			default: return DATA_W'($urandom());
		endcase
	endfunction

	// offer one request and hold it until it is taken
	task automatic send_request(logic op, logic [WEIGHT_W-1:0] w, logic [DATA_W-1:0] d,
			logic [DATA_W-1:0] t, logic [DATA_W-1:0] v, logic l);
		in_valid <= 1'b1;
		opcode   <= op;
		weight   <= w;
		distance <= d;
		target   <= t;
		value    <= v;
		last     <= l;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(op, w, d, t, v, l);
		requests_sent++;
	endtask

	task automatic pause(int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = pick_gap();
		if (n > 0)
			pause(n);
	endtask

	// element of a data set, the scale field carries noise
	task automatic send_element(logic [WEIGHT_W-1:0] w, logic [DATA_W-1:0] d,
			logic [DATA_W-1:0] t, logic l);
		send_request(OP_ACCUM, w, d, t, DATA_W'($urandom()), l);
	endtask

	// scale request, the element fields and last carry noise
	task automatic send_scale(logic [DATA_W-1:0] v);
		send_request(OP_SCALE, pick_weight(), DATA_W'($urandom()), DATA_W'($urandom()), v,
			1'($urandom_range(0, 1)));
	endtask

	// stop offering until every owed result has come, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// one data set with random content, sometimes zero-weighted or broken up
	task automatic random_data_set();
		int  n;
		int  r;
		int  k;
		bit  degenerate;
		logic [WEIGHT_W-1:0] w;
		logic [DATA_W-1:0]   d;
		calm = ($urandom_range(0, 9) == 0);
		r = $urandom_range(0, 99);
		if (r < 70)
			n = $urandom_range(1, 8);
		else if (r < 92)
			n = $urandom_range(9, 40);
		else
			n = $urandom_range(41, 256);
		degenerate = ($urandom_range(0, 9) == 0);
		for (k = 0; k < n; k++) begin
			idle_gap();
			if ($urandom_range(0, 15) == 0) begin
				send_scale(pick_value());
				idle_gap();
			end
			w = pick_weight();
			d = pick_data();
			if (degenerate) begin
				if ($urandom_range(0, 1) == 1)
					w = '0;
				else
					d = DATA_W'($urandom_range(0, 1));
			end
			send_element(w, d, pick_data(), k == n - 1);
		end
		// broken sequence: raw requests with random opcode and last
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				idle_gap();
				send_request(1'($urandom_range(0, 1)), pick_weight(), pick_data(), pick_data(),
					pick_value(), 1'($urandom_range(0, 1)));
			end
		end
		repeat ($urandom_range(0, 5)) begin
			idle_gap();
			send_scale(pick_value());
		end
		if ($urandom_range(0, 24) == 0)
			drain();
	endtask

	// result side: check each accepted result and drive stall
	initial begin : result_sink
		int   stall_left;
		int   hold_left;
		logic hold_ack;
		stall_left = 0;
		hold_left  = 0;
		hold_ack   = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(kind, result_value, divide_by_zero);
			if (hold_off_req != hold_ack) begin
				hold_ack  = hold_off_req;
				hold_left = HOLD_OFF_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (calm) begin
				out_stall <= 1'b0;
			end else begin
				out_stall  <= ($urandom_range(0, 2) == 0);
				stall_left = pick_gap();
			end
		end
	end

	initial begin : timeout
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int k;
		int random_start;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of value with the reset factor of one, last ignored on a scale
		send_scale(RES_MAX);
		send_scale(RES_MIN);
		send_scale('0);
		send_request(OP_SCALE, W_ONE, D_MAX, D_MAX, {DATA_W{1'b1}}, 1'b1);
		send_scale(DATA_W'(1));
		// zero weight: square sum zero, factor kept
		send_element('0, D_MAX, D_MAX, 1'b1);
		// square product truncates to zero while the cross product does not
		send_element(16'd1, 24'd1, D_MAX, 1'b1);
		// equal distance and target give exactly one
		send_element(W_ONE, D_MAX, D_MAX, 1'b0);
		send_element(W_ONE, D_MAX, D_MAX, 1'b1);
		// tiny distance, huge target: factor saturates
		send_element(W_ONE, 24'd256, D_MAX, 1'b1);
		// scaling by the saturated factor saturates both ways
		send_scale(RES_MAX);
		send_scale(RES_MIN);
		send_scale({DATA_W{1'b1}});
		send_scale(DATA_W'(1));
		send_scale(24'h000100);
		// zero target gives a zero factor
		send_element(W_ONE, D_MAX, '0, 1'b1);
		send_scale(RES_MIN);
		send_scale(RES_MAX);
		// factor of one half exercises rounding half up on both signs
		send_element(W_ONE, 24'h020000, 24'h010000, 1'b1);
		send_scale({DATA_W{1'b1}});
		send_scale(DATA_W'(1));
		send_scale(-DATA_W'(3));
		drain();

		// long receiver hold-off while requests keep coming, the block backs up
		calm = 1'b1;
		hold_off_req = ~hold_off_req;
		for (k = 0; k < 30; k++)
			send_scale(pick_value());
		drain();

		// a long set of large elements drives the cross sum into saturation
		for (k = 0; k < 560; k++)
			send_element(W_ONE, 24'hF00000, D_MAX, k == 559);
		send_scale(RES_MAX);
		drain();

		random_start = requests_sent;
		while (requests_sent - random_start < RANDOM_ITEMS)
			random_data_set();
		calm = 1'b0;
		drain();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
